### rtl/tcch_pkg.sv
package tcch_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int SQRT_STEPS          = 15;
  localparam int DIV_STEPS           = 15;
  localparam int ATAN_TABLE_LEN      = 24;
  localparam int DEG_SHIFT           = 20;
  // Vector datapath width: the rotated field is below 2^47, the CORDIC gain adds under one bit.
  localparam int CW = 51;
  // Angle accumulator width, degrees scaled by 2^20, signed.
  localparam int ZW = 31;

  localparam logic [28:0]          ONE_SQ = 29'h1000_0000;
  localparam logic [15:0]          ONE_Q14 = 16'd16384;
  localparam logic signed [ZW-1:0] DEG180 = 31'sd188743680;
  localparam logic signed [ZW-1:0] DEG360 = 31'sd377487360;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] ay;
    logic signed [16:0] mx;
    logic signed [16:0] my;
    logic signed [16:0] mz;
    logic signed [15:0] sp;
    logic [14:0]        cp;
    logic signed [15:0] sr;
    logic [14:0]        cr;
    logic               clamp;
  } item_t;

  typedef struct packed {
    logic [28:0] v;
    logic [29:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [14:0]        rem;
    logic [14:0]        q;
    logic [14:0]        nb;
    logic               div_en;
    logic               neg;
    logic signed [15:0] sr_fix;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  // One step of the digit-by-digit square root, result bit weight 2^(14-j).
  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned j);
    sqrt_t       r;
    logic [29:0] b;
    logic [29:0] t;
    b = 30'(1) << (28 - 2 * j);
    t = s.res + b;
    if ({1'b0, s.v} >= t) begin
      r.v   = s.v - t[28:0];
      r.res = (s.res >> 1) + b;
    end else begin
      r.v   = s.v;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  // atan(2^-i) in degrees times 2^20, rounded.
  function automatic logic signed [ZW-1:0] atan_deg(int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 31'sd47185920;
      1:  a = 31'sd27855475;
      2:  a = 31'sd14718068;
      3:  a = 31'sd7471121;
      4:  a = 31'sd3750058;
      5:  a = 31'sd1876857;
      6:  a = 31'sd938658;
      7:  a = 31'sd469357;
      8:  a = 31'sd234682;
      9:  a = 31'sd117342;
      10: a = 31'sd58671;
      11: a = 31'sd29335;
      12: a = 31'sd14668;
      13: a = 31'sd7334;
      14: a = 31'sd3667;
      15: a = 31'sd1833;
      16: a = 31'sd917;
      17: a = 31'sd458;
      18: a = 31'sd229;
      19: a = 31'sd115;
      20: a = 31'sd57;
      21: a = 31'sd29;
      22: a = 31'sd14;
      23: a = 31'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Vectors in the left half plane are turned by 180 degrees first.
  function automatic lane_t lane_init(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.x = -x;
      l.y = -y;
      l.z = DEG180;
    end else begin
      l.x = x;
      l.y = y;
      l.z = '0;
    end
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, int unsigned i);
    lane_t                r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = l.y >>> i;
    dy = l.x >>> i;
    r.zero = l.zero;
    if (l.y >= 0) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + atan_deg(i);
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - atan_deg(i);
    end
    return r;
  endfunction

endpackage

### rtl/tilt_compensated_compass_heading_top.sv
// Tilt-compensated compass heading. Every input beat carries one accelerometer
// sample (x and y, 16384 counts per g) and one raw magnetometer sample; every
// output beat carries the plain heading atan2(my, mx) of the offset-corrected
// field, the heading after rotating the field into the horizontal plane with
// pitch = asin(-ax) and roll = asin(ay / cos pitch), and a flag that is set
// when either asin argument lay beyond +-1 and was clamped. Headings are
// degrees times 2^ANGLE_FRAC_BITS in 0..360 (360 excluded); a zero vector
// reads as heading 0. The block is a fully pipelined datapath: it takes one
// beat every clock unless a finished result is held at the output. The path
// runs through the two 15-step square-root pipelines (cos pitch and cos
// roll), the 15-step divider for sin roll, three multiply stages and the
// CORDIC vectoring pipeline with one step per stage. A valid bit travels with
// every stage; when the output beat is not taken the whole pipeline holds, so
// in_tready follows out_tready whenever a result is waiting. The hard-iron
// offsets are written through the cfg port and are subtracted at the entry
// stage; the user must write them only while the stream is idle, which the
// block itself does not enforce.
module tilt_compensated_compass_heading_top #(
  parameter int ANGLE_FRAC_BITS = tcch_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tcch_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accel_x[15:0], accel_y[31:16], mag_x[47:32], mag_y[63:48], mag_z[79:64]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // heading_flat[14:0], heading_tilted[29:15], tilt_clamped[30], zero pad[31]
  output logic [31:0] out_tdata
);
  import tcch_pkg::*;

  localparam int RND_SHIFT = DEG_SHIFT - ANGLE_FRAC_BITS;
  localparam logic [ZW-1:0] RND_HALF = ZW'(1) << (RND_SHIFT - 1);
  localparam logic [ZW-1:0] FULL = ZW'(360) << ANGLE_FRAC_BITS;

  // Hard-iron offsets.
  logic signed [15:0] off_x_r, off_y_r, off_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: off_x_r <= cfg_wdata;
        REG_OFFSET_Y: off_y_r <= cfg_wdata;
        REG_OFFSET_Z: off_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished beat is stuck at the output.
  logic out_valid_r;
  logic en;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Entry stage: offset correction and the pitch sine with its clamp.
  logic signed [15:0] ax_in;
  item_t s0_nxt, s0_item_r;
  logic  s0_vld_r;

  always_comb begin
    ax_in        = signed'(in_tdata[15:0]);
    s0_nxt       = '0;
    s0_nxt.ay    = signed'(in_tdata[31:16]);
    s0_nxt.mx    = 17'(signed'(in_tdata[47:32])) - 17'(off_x_r);
    s0_nxt.my    = 17'(signed'(in_tdata[63:48])) - 17'(off_y_r);
    s0_nxt.mz    = 17'(signed'(in_tdata[79:64])) - 17'(off_z_r);
    if (ax_in < -16'sd16384) begin
      s0_nxt.sp    = 16'sd16384;
      s0_nxt.clamp = 1'b1;
    end else if (ax_in > 16'sd16384) begin
      s0_nxt.sp    = -16'sd16384;
      s0_nxt.clamp = 1'b1;
    end else begin
      s0_nxt.sp    = -ax_in;
      s0_nxt.clamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) s0_item_r <= s0_nxt;
  end

  // Square root for cos pitch: radicand stage then one result bit per stage.
  item_t sqa_item_r [SQRT_STEPS+1];
  sqrt_t sqa_r      [SQRT_STEPS+1];
  logic  sqa_vld_r  [SQRT_STEPS+1];
  logic signed [31:0] sp_sq;

  assign sp_sq = s0_item_r.sp * s0_item_r.sp;

  always_ff @(posedge clk) begin
    if (!rst_n) sqa_vld_r[0] <= 1'b0;
    else if (en) sqa_vld_r[0] <= s0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_item_r[0] <= s0_item_r;
      sqa_r[0].v    <= ONE_SQ - sp_sq[28:0];
      sqa_r[0].res  <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : gen_sqa
    always_ff @(posedge clk) begin
      if (!rst_n) sqa_vld_r[j+1] <= 1'b0;
      else if (en) sqa_vld_r[j+1] <= sqa_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqa_item_r[j+1] <= sqa_item_r[j];
        sqa_r[j+1]      <= sqrt_step(sqa_r[j], j);
      end
    end
  end

  // Roll sine: clamp tests, then a restoring divider for |ay| * 2^14 / cp.
  item_t dv_item_r [DIV_STEPS+1];
  div_t  dv_r      [DIV_STEPS+1];
  logic  dv_vld_r  [DIV_STEPS+1];
  item_t dp_item;
  div_t  dp_nxt;
  logic [15:0] ay_mag;

  always_comb begin
    dp_item    = sqa_item_r[SQRT_STEPS];
    dp_item.cp = sqa_r[SQRT_STEPS].res[14:0];
    ay_mag     = dp_item.ay[15] ? 16'(-dp_item.ay) : 16'(dp_item.ay);
    dp_nxt     = '0;
    dp_nxt.neg = dp_item.ay[15];
    dp_nxt.rem = ay_mag[15:1];
    dp_nxt.nb  = {ay_mag[0], 14'd0};
    if (ay_mag > {1'b0, dp_item.cp}) begin
      // Beyond +-1: saturate to the sign of ay.
      dp_nxt.sr_fix = dp_item.ay[15] ? -16'sd16384 : 16'sd16384;
      dp_item.clamp = 1'b1;
    end else if (dp_item.cp == '0) begin
      // Vertical pitch with zero ay gives zero roll, no flag.
      dp_nxt.sr_fix = '0;
    end else begin
      dp_nxt.div_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (en) dv_vld_r[0] <= sqa_vld_r[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_item_r[0] <= dp_item;
      dv_r[0]      <= dp_nxt;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : gen_div
    logic [15:0] trial;
    div_t        nxt;
    always_comb begin
      trial = {dv_r[j].rem, dv_r[j].nb[14]};
      nxt   = dv_r[j];
      nxt.nb = {dv_r[j].nb[13:0], 1'b0};
      if (trial >= {1'b0, dv_item_r[j].cp}) begin
        nxt.rem = 15'(trial - {1'b0, dv_item_r[j].cp});
        nxt.q   = {dv_r[j].q[13:0], 1'b1};
      end else begin
        nxt.rem = trial[14:0];
        nxt.q   = {dv_r[j].q[13:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[j+1] <= 1'b0;
      else if (en) dv_vld_r[j+1] <= dv_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_item_r[j+1] <= dv_item_r[j];
        dv_r[j+1]      <= nxt;
      end
    end
  end

  // Signed roll sine.
  item_t sr_item_r, sr_nxt;
  logic  sr_vld_r;
  logic signed [15:0] q_s;

  always_comb begin
    sr_nxt = dv_item_r[DIV_STEPS];
    q_s    = signed'({1'b0, dv_r[DIV_STEPS].q});
    if (dv_r[DIV_STEPS].div_en) sr_nxt.sr = dv_r[DIV_STEPS].neg ? -q_s : q_s;
    else sr_nxt.sr = dv_r[DIV_STEPS].sr_fix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sr_vld_r <= 1'b0;
    else if (en) sr_vld_r <= dv_vld_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) sr_item_r <= sr_nxt;
  end

  // Square root for cos roll.
  item_t sqb_item_r [SQRT_STEPS+1];
  sqrt_t sqb_r      [SQRT_STEPS+1];
  logic  sqb_vld_r  [SQRT_STEPS+1];
  logic signed [31:0] sr_sq;

  assign sr_sq = sr_item_r.sr * sr_item_r.sr;

  always_ff @(posedge clk) begin
    if (!rst_n) sqb_vld_r[0] <= 1'b0;
    else if (en) sqb_vld_r[0] <= sr_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqb_item_r[0] <= sr_item_r;
      sqb_r[0].v    <= ONE_SQ - sr_sq[28:0];
      sqb_r[0].res  <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : gen_sqb
    always_ff @(posedge clk) begin
      if (!rst_n) sqb_vld_r[j+1] <= 1'b0;
      else if (en) sqb_vld_r[j+1] <= sqb_vld_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqb_item_r[j+1] <= sqb_item_r[j];
        sqb_r[j+1]      <= sqrt_step(sqb_r[j], j);
      end
    end
  end

  // Rotation into the horizontal plane, three multiply stages.
  item_t ma_item;
  logic signed [15:0] cp_s, cr_s;

  always_comb begin
    ma_item    = sqb_item_r[SQRT_STEPS];
    ma_item.cr = sqb_r[SQRT_STEPS].res[14:0];
    cp_s       = signed'({1'b0, ma_item.cp});
    cr_s       = signed'({1'b0, ma_item.cr});
  end

  item_t ma_item_r, mb_item_r, mc_item_r;
  logic  ma_vld_r, mb_vld_r, mc_vld_r;
  logic signed [32:0] ma_p1_r, ma_p2_r, ma_p4_r;
  logic signed [30:0] ma_p3_r, ma_p5_r;
  logic signed [CW-1:0] mb_xh_r, mb_q1_r, mb_q2_r, mb_q3_r;
  logic signed [CW-1:0] mc_xh_r, mc_yh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_vld_r <= 1'b0;
      mb_vld_r <= 1'b0;
      mc_vld_r <= 1'b0;
    end else if (en) begin
      ma_vld_r <= sqb_vld_r[SQRT_STEPS];
      mb_vld_r <= ma_vld_r;
      mc_vld_r <= mb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_item_r <= ma_item;
      ma_p1_r   <= ma_item.mx * cp_s;
      ma_p2_r   <= ma_item.mz * ma_item.sp;
      ma_p3_r   <= ma_item.sr * ma_item.sp;
      ma_p4_r   <= ma_item.my * cr_s;
      ma_p5_r   <= ma_item.sr * cp_s;

      mb_item_r <= ma_item_r;
      mb_xh_r   <= (CW'(ma_p1_r) + CW'(ma_p2_r)) <<< 14;
      mb_q1_r   <= ma_item_r.mx * ma_p3_r;
      mb_q2_r   <= CW'(ma_p4_r) <<< 14;
      mb_q3_r   <= ma_item_r.mz * ma_p5_r;

      mc_item_r <= mb_item_r;
      mc_xh_r   <= mb_xh_r;
      mc_yh_r   <= mb_q1_r + mb_q2_r - mb_q3_r;
    end
  end

  // CORDIC vectoring, flat and tilted lanes side by side.
  lane_t cf_r     [CORDIC_STEPS+1];
  lane_t ct_r     [CORDIC_STEPS+1];
  logic  cc_clamp_r [CORDIC_STEPS+1];
  logic  cc_vld_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) cc_vld_r[0] <= 1'b0;
    else if (en) cc_vld_r[0] <= mc_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf_r[0]       <= lane_init(CW'(mc_item_r.mx) <<< 28, CW'(mc_item_r.my) <<< 28);
      ct_r[0]       <= lane_init(mc_xh_r, mc_yh_r);
      cc_clamp_r[0] <= mc_item_r.clamp;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : gen_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) cc_vld_r[i+1] <= 1'b0;
      else if (en) cc_vld_r[i+1] <= cc_vld_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cf_r[i+1]       <= cordic_step(cf_r[i], i);
        ct_r[i+1]       <= cordic_step(ct_r[i], i);
        cc_clamp_r[i+1] <= cc_clamp_r[i];
      end
    end
  end

  // Wrap into [0, 360): the angle never reaches a full turn, only negatives need it.
  lane_t cf_end, ct_end;
  logic [ZW-1:0] wr_zf_r, wr_zt_r;
  logic          wr_zero_f_r, wr_zero_t_r, wr_clamp_r, wr_vld_r;

  assign cf_end = cf_r[CORDIC_STEPS];
  assign ct_end = ct_r[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) wr_vld_r <= 1'b0;
    else if (en) wr_vld_r <= cc_vld_r[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_zf_r     <= unsigned'((cf_end.z < 0) ? cf_end.z + DEG360 : cf_end.z);
      wr_zt_r     <= unsigned'((ct_end.z < 0) ? ct_end.z + DEG360 : ct_end.z);
      wr_zero_f_r <= cf_end.zero;
      wr_zero_t_r <= ct_end.zero;
      wr_clamp_r  <= cc_clamp_r[CORDIC_STEPS];
    end
  end

  // Round half up to the output scale; a result of exactly 360 degrees becomes 0.
  logic [ZW-1:0] hf_rnd, ht_rnd, hf_fin, ht_fin;
  logic [14:0]   out_hf_r, out_ht_r;
  logic          out_clamp_r;

  always_comb begin
    hf_rnd = (wr_zf_r + RND_HALF) >> RND_SHIFT;
    ht_rnd = (wr_zt_r + RND_HALF) >> RND_SHIFT;
    hf_fin = (hf_rnd >= FULL) ? hf_rnd - FULL : hf_rnd;
    ht_fin = (ht_rnd >= FULL) ? ht_rnd - FULL : ht_rnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= wr_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hf_r    <= wr_zero_f_r ? '0 : hf_fin[14:0];
      out_ht_r    <= wr_zero_t_r ? '0 : ht_fin[14:0];
      out_clamp_r <= wr_clamp_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_clamp_r, out_ht_r, out_hf_r};

  // A zero flat field vector must come out as flat heading zero.
  a_zero_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (en && wr_vld_r && wr_zero_f_r) |=> (out_hf_r == '0))
    else $error("zero flat vector did not give heading zero");

  // While the output is blocked the entry stage must hold its valid bit.
  a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s0_vld_r))
    else $error("entry stage moved during a stall");

  // cos pitch never exceeds one in Q14.
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sqa_vld_r[SQRT_STEPS] |-> (sqa_r[SQRT_STEPS].res <= 30'd16384))
    else $error("cos pitch out of range");

  // The roll quotient stays within one in Q14 when the divider is used.
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[DIV_STEPS] && dv_r[DIV_STEPS].div_en) |-> (dv_r[DIV_STEPS].q <= 15'd16384))
    else $error("roll quotient out of range");

endmodule

### test/tilt_compensated_compass_heading_top_tb.sv
`timescale 1ns / 100ps

module tilt_compensated_compass_heading_top_tb;
  import tcch_pkg::*;

  localparam int   FULL_TURN   = 360 << 6;
  localparam int   IDLE_PCT    = 29;
  localparam int   HOLD_CYCLES = 400;
  localparam int   CYCLE_LIMIT = 300000;
  localparam int   DRAIN_WAIT  = 150;

  // One sensor sample as it is carried by an input beat.
  typedef struct packed {
    logic signed [15:0] mag_z;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } sample_t;

  // One result as it is carried by an output beat, highest field first.
  typedef struct packed {
    logic        tilt_clamped;
    logic [14:0] heading_tilted;
    logic [14:0] heading_flat;
  } heading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_OFFSET_X;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // Shadow copy of the hard-iron offsets, updated as each register write is issued.
  logic signed [15:0] hard_iron [3];

  sample_t  samples_to_send [$];
  heading_t headings_due [$];
  int       beats_in = 0;
  int       beats_out = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       failed = 1'b0;

  tilt_compensated_compass_heading_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Integer square root, digit by digit, floor of the true root.
  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitw;
    res  = 0;
    bitw = 64'd1 << 30;
    while (bitw > v) bitw = bitw >> 2;
    while (bitw != 0) begin
      if (v >= res + bitw) begin
        v   = v - (res + bitw);
        res = (res >> 1) + bitw;
      end else begin
        res = res >> 1;
      end
      bitw = bitw >> 2;
    end
    return longint'(res);
  endfunction

  // CORDIC vectoring atan2 in degrees scaled by 2^20, then rounded to 6 fraction bits.
  function automatic logic [14:0] vector_heading(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    longint rounded;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(180) << 20;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_deg(i));
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_deg(i));
      end
    end
    while (z < 0) z = z + (longint'(360) << 20);
    while (z >= (longint'(360) << 20)) z = z - (longint'(360) << 20);
    rounded = (z + (longint'(1) << 13)) >>> 14;
    if (rounded >= FULL_TURN) rounded = rounded - FULL_TURN;
    return rounded[14:0];
  endfunction

  function automatic heading_t compass_headings(sample_t s);
    heading_t h;
    longint   ax;
    longint   ay;
    longint   mx;
    longint   my;
    longint   mz;
    longint   sp;
    longint   cp;
    longint   sr;
    longint   cr;
    longint   mag;
    longint   xh;
    longint   yh;
    ax = s.accel_x;
    ay = s.accel_y;
    mx = longint'(s.mag_x) - longint'(hard_iron[REG_OFFSET_X]);
    my = longint'(s.mag_y) - longint'(hard_iron[REG_OFFSET_Y]);
    mz = longint'(s.mag_z) - longint'(hard_iron[REG_OFFSET_Z]);
    h.tilt_clamped = 1'b0;
    // Pitch sine beyond one g is clamped and flagged.
    sp = -ax;
    if (sp > 16384) begin
      sp = 16384;
      h.tilt_clamped = 1'b1;
    end else if (sp < -16384) begin
      sp = -16384;
      h.tilt_clamped = 1'b1;
    end
    cp = int_sqrt(64'(longint'(1) << 28) - 64'(sp * sp));
    mag = (ay < 0) ? -ay : ay;
    if (mag > cp) begin
      sr = (ay < 0) ? -16384 : 16384;
      h.tilt_clamped = 1'b1;
    end else if (cp == 0) begin
      sr = 0;
    end else begin
      sr = (mag * 16384) / cp;
      if (ay < 0) sr = -sr;
    end
    cr = int_sqrt(64'(longint'(1) << 28) - 64'(sr * sr));
    xh = (mx * cp + mz * sp) * 16384;
    yh = mx * sr * sp + my * cr * 16384 - mz * sr * cp;
    h.heading_flat   = vector_heading(mx <<< 28, my <<< 28);
    h.heading_tilted = vector_heading(xh, yh);
    return h;
  endfunction

  // Sender: presents the oldest pending sample and records its expected headings
  // at the edge where the beat is accepted. Between beats 900 and 1150 it never idles while samples are pending.
  always @(posedge clk) begin
    bit fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        headings_due.push_back(compass_headings(samples_to_send.pop_front()));
        beats_in++;
      end
      if (!in_tvalid || fire) begin
        if (samples_to_send.size() > 0 &&
            ((beats_in >= 900 && beats_in < 1150) || $urandom_range(99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= samples_to_send[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted result against the oldest expectation. Once,
  // after 400 samples have gone in, it holds off long enough for the pipeline to
  // fill and push back on the input.
  always @(posedge clk) begin
    heading_t got;
    heading_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[30:0];
        beats_out++;
        if (headings_due.size() == 0) begin
          $error("result beat with no expectation waiting: %h", out_tdata);
          failed = 1'b1;
        end else begin
          want = headings_due.pop_front();
          if (got.heading_flat !== want.heading_flat) begin
            $error("heading_flat expected %0d actual %0d", want.heading_flat, got.heading_flat);
            failed = 1'b1;
          end
          if (got.heading_tilted !== want.heading_tilted) begin
            $error("heading_tilted expected %0d actual %0d",
                   want.heading_tilted, got.heading_tilted);
            failed = 1'b1;
          end
          if (got.tilt_clamped !== want.tilt_clamped) begin
            $error("tilt_clamped expected %0d actual %0d", want.tilt_clamped, got.tilt_clamped);
            failed = 1'b1;
          end
        end
      end
      if (!hold_done && beats_in >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (beats_out >= 900 && beats_out < 1150) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tilt_compensated_compass_heading_top_tb failed");
      $finish;
    end
  end

  task automatic write_offset(reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    hard_iron[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_offsets(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
    write_offset(REG_OFFSET_X, ox);
    write_offset(REG_OFFSET_Y, oy);
    write_offset(REG_OFFSET_Z, oz);
  endtask

  function automatic sample_t make_sample(int ax, int ay, int mx, int my, int mz);
    sample_t s;
    s.accel_x = ax[15:0];
    s.accel_y = ay[15:0];
    s.mag_x   = mx[15:0];
    s.mag_y   = my[15:0];
    s.mag_z   = mz[15:0];
    return s;
  endfunction

  // Mostly tilts inside one g, so the compensation path is exercised; the rest
  // are full-range words that hit the clamps and every bit.
  function automatic sample_t random_sample();
    sample_t s;
    s = '0;
    s.mag_x = 16'($urandom);
    s.mag_y = 16'($urandom);
    s.mag_z = 16'($urandom);
    if ($urandom_range(99) < 75) begin
      s.accel_x = 16'(int'($urandom_range(32768)) - 16384);
      s.accel_y = 16'(int'($urandom_range(32768)) - 16384);
    end else begin
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
    end
    if ($urandom_range(99) < 5) begin
      // Horizontal field (x and y) exactly at the hard-iron center.
      s.mag_x = hard_iron[REG_OFFSET_X];
      s.mag_y = hard_iron[REG_OFFSET_Y];
    end
    return s;
  endfunction

  task automatic wait_drained();
    wait (samples_to_send.size() == 0 && headings_due.size() == 0 && !in_tvalid);
    @(posedge clk);
  endtask

  initial begin
    hard_iron[REG_OFFSET_X] = '0;
    hard_iron[REG_OFFSET_Y] = '0;
    hard_iron[REG_OFFSET_Z] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_offsets(16'd0, 16'd0, 16'd0);

    // Directed samples: level, vertical pitch both ways, clamped pitch and roll,
    // field extremes and the zero field.
    samples_to_send.push_back(make_sample(0, 0, 1000, 0, 0));
    samples_to_send.push_back(make_sample(0, 0, 0, 1000, 0));
    samples_to_send.push_back(make_sample(0, 0, -1000, 0, 0));
    samples_to_send.push_back(make_sample(0, 0, 0, -1000, 0));
    samples_to_send.push_back(make_sample(0, 0, 0, 0, 0));
    samples_to_send.push_back(make_sample(0, 0, 0, 0, 500));
    samples_to_send.push_back(make_sample(16384, 0, 300, -200, 700));
    samples_to_send.push_back(make_sample(-16384, 0, 300, -200, 700));
    samples_to_send.push_back(make_sample(16384, 5, 300, 200, -700));
    samples_to_send.push_back(make_sample(32767, 0, 1, 1, 1));
    samples_to_send.push_back(make_sample(-32768, -32768, -1, 1, -1));
    samples_to_send.push_back(make_sample(0, 32767, 4000, 4000, 4000));
    samples_to_send.push_back(make_sample(0, -32768, -4000, 4000, -4000));
    samples_to_send.push_back(make_sample(0, 16384, 2000, -3000, 100));
    samples_to_send.push_back(make_sample(8000, 14000, -2000, 3000, 100));
    samples_to_send.push_back(make_sample(-11585, 11585, 1500, 1500, 1500));
    samples_to_send.push_back(make_sample(0, 0, 32767, 32767, 32767));
    samples_to_send.push_back(make_sample(0, 0, -32768, -32768, -32768));
    samples_to_send.push_back(make_sample(-9000, -6000, 32767, -32768, 32767));
    samples_to_send.push_back(make_sample(5000, 2000, -32768, 32767, -32768));
    wait_drained();

    // Random phases, each with its own offsets, including both extremes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_offsets(16'h7FFF, 16'h8000, 16'h7FFF);
        1: set_offsets(16'h8000, 16'h7FFF, 16'h8000);
        2: set_offsets(16'd0, 16'd0, 16'd0);
        default: set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (int n = 0; n < 306; n++) samples_to_send.push_back(random_sample());
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed && headings_due.size() == 0) begin
      $display("tilt_compensated_compass_heading_top_tb passed");
    end else begin
      $display("tilt_compensated_compass_heading_top_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tcch_pkg.sv
rtl/tilt_compensated_compass_heading_top.sv
test/tilt_compensated_compass_heading_top_tb.sv
